FILE: rtl/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
// Included by the checker module; needs nothing else.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// implication checked on the same edge
`define RMQ_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// implication checked at the following edge
`define RMQ_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

// check that does not turn off during reset
`define RMQ_ASSERT_RST(label, clk, a, c, msg) \
  label: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/rmq_pkg.sv
// Shared constants and routing codes for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // which quaternion part receives the square-root term
  typedef enum logic [1:0] {
    ROUTE_S = 2'd0,
    ROUTE_I = 2'd1,
    ROUTE_J = 2'd2,
    ROUTE_K = 2'd3
  } route_t;
endpackage

FILE: rtl/rmq_front.sv
// Front end: case pick, radicand and off-diagonal sums/differences.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int XW         = DATA_WIDTH + FRAC_BITS + ((DATA_WIDTH + FRAC_BITS) % 2)
) (
  input  logic signed [DATA_WIDTH-1:0] c0_x, c0_y, c0_z,
  input  logic signed [DATA_WIDTH-1:0] c1_x, c1_y, c1_z,
  input  logic signed [DATA_WIDTH-1:0] c2_x, c2_y, c2_z,
  output logic        [XW-1:0]         rad_x,
  output logic signed [DATA_WIDTH:0]   d0, d1, d2,
  output route_t                       route
);
  localparam int RW = DATA_WIDTH + 3;
  logic signed [RW-1:0] m00, m11, m22, trace, r, rc;
  logic signed [DATA_WIDTH:0] m01, m02, m10, m12, m20, m21;

  always_comb begin
    m00 = RW'(c0_x);
    m11 = RW'(c1_y);
    m22 = RW'(c2_z);
    m21 = (DATA_WIDTH+1)'(c1_z);
    m12 = (DATA_WIDTH+1)'(c2_y);
    m02 = (DATA_WIDTH+1)'(c2_x);
    m20 = (DATA_WIDTH+1)'(c0_z);
    m10 = (DATA_WIDTH+1)'(c0_y);
    m01 = (DATA_WIDTH+1)'(c1_x);
    trace = m00 + m11 + m22;
    if (trace > 0) begin
      route = ROUTE_S;
      r  = trace + (RW'(1) <<< FRAC_BITS);
      d0 = m21 - m12;
      d1 = m02 - m20;
      d2 = m10 - m01;
    end else if (m22 > ((m11 > m00) ? m11 : m00)) begin
      route = ROUTE_K;
      r  = m22 - (m00 + m11) + (RW'(1) <<< FRAC_BITS);
      d0 = m10 - m01;
      d1 = m02 + m20;
      d2 = m12 + m21;
    end else if (m11 > m00) begin
      route = ROUTE_J;
      r  = m11 - (m22 + m00) + (RW'(1) <<< FRAC_BITS);
      d0 = m02 - m20;
      d1 = m21 + m12;
      d2 = m01 + m10;
    end else begin
      route = ROUTE_I;
      r  = m00 - (m11 + m22) + (RW'(1) <<< FRAC_BITS);
      d0 = m21 - m12;
      d1 = m10 + m01;
      d2 = m20 + m02;
    end
    // radicand floor of one raw unit keeps the divisor nonzero
    rc    = (r < RW'(1)) ? RW'(1) : r;
    rad_x = XW'(rc[DATA_WIDTH+1:0]) << (FRAC_BITS - 2);
  end
endmodule

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion, Shepperd's method, fully pipelined.
// Depends on rmq_pkg and rmq_front.
//
// Usage:
//  - Input word: nine signed fixed-point matrix entries (c0..c2 columns,
//    x/y/z rows) on in_valid/in_ready. Output word: q_scalar, q_i, q_j, q_k
//    on out_valid/out_ready. A word moves when valid and ready are high.
//  - Pipeline: one front stage, one square-root stage per result bit, a
//    rounding stage, a numerator stage, one restoring divide stage per
//    quotient bit (three lanes side by side) and an output stage.
//  - Throughput: one word per cycle when not stalled; one word per stage.
//  - Stall: each stage moves up when the stage after it is empty or moving,
//    so a stalled receiver only backs up the full stages; empty slots keep
//    filling and in_ready drops only once every stage holds a word.
//  - Reset (rst, synchronous): clears all stage valid bits; nothing else.
//  - Results round to nearest; the square-root term is sqrt(radicand)/2 and
//    the other parts are d/(4*big) scaled, all saturated to DATA_WIDTH bits.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] c0_x, c0_y, c0_z,
  input  logic signed [DATA_WIDTH-1:0] c1_x, c1_y, c1_z,
  input  logic signed [DATA_WIDTH-1:0] c2_x, c2_y, c2_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] q_scalar,
  output logic signed [DATA_WIDTH-1:0] q_i,
  output logic signed [DATA_WIDTH-1:0] q_j,
  output logic signed [DATA_WIDTH-1:0] q_k
);
  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int XW   = W + F + ((W + F) % 2);  // radicand word, even width
  localparam int NS   = XW / 2;                  // root bits = sqrt stages
  localparam int RW   = W + F + NS + 4;          // divide remainder width
  localparam int S_RND = NS + 1;                 // rounding stage
  localparam int S_NUM = NS + 2;                 // numerator stage
  localparam int S_DIV = NS + 3;                 // first divide stage
  localparam int S_OUT = NS + W + 3;             // output register
  localparam int L     = S_OUT + 1;
  localparam logic [W-1:0] HI  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LO  = {1'b1, {(W-1){1'b0}}};

  logic                 v   [L];
  logic                 rdy [L];
  logic [XW-1:0]        xs  [L];
  logic [NS+2:0]        srem[L];
  logic [NS-1:0]        root[L];
  logic [NS:0]          big [L];
  logic [RW-1:0]        den [L];
  route_t               rt  [L];
  logic signed [W:0]    dv  [3][L];
  logic [RW-1:0]        num [3][L];
  logic [W-1:0]         qt  [3][L];
  logic                 ovf [3][L];
  logic [W-1:0]         res [4];

  logic [XW-1:0]     f_x;
  logic signed [W:0] f_d0, f_d1, f_d2;
  route_t            f_rt;

  rmq_front #(.DATA_WIDTH(W), .FRAC_BITS(F), .XW(XW)) u_front (
    .c0_x(c0_x), .c0_y(c0_y), .c0_z(c0_z),
    .c1_x(c1_x), .c1_y(c1_y), .c1_z(c1_z),
    .c2_x(c2_x), .c2_y(c2_y), .c2_z(c2_z),
    .rad_x(f_x), .d0(f_d0), .d1(f_d1), .d2(f_d2), .route(f_rt)
  );

  // per-stage ready: a stage may load when it is empty or its word leaves
  always_comb begin
    rdy[L-1] = !v[L-1] || out_ready;
    for (int s = L - 2; s >= 0; s--) begin
      rdy[s] = !v[s] || rdy[s+1];
    end
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < L; s++) v[s] <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int s = 1; s < L; s++) begin
        if (rdy[s]) v[s] <= v[s-1];
      end
    end
  end

  // front stage
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xs[0]    <= f_x;
      srem[0]  <= '0;
      root[0]  <= '0;
      big[0]   <= '0;
      den[0]   <= '0;
      rt[0]    <= f_rt;
      dv[0][0] <= f_d0;
      dv[1][0] <= f_d1;
      dv[2][0] <= f_d2;
      for (int l = 0; l < 3; l++) begin
        num[l][0] <= '0;
        qt[l][0]  <= '0;
        ovf[l][0] <= 1'b0;
      end
    end
  end

  genvar s, l;
  generate
    for (s = 1; s < L; s++) begin : g_stage
      logic [NS+2:0] rin, trial;
      logic [NS:0]   bg;
      logic [RW-1:0] nm   [3];
      logic [RW-1:0] dsh;
      logic [W:0]    mag  [3];

      always_comb begin
        rin   = {srem[s-1][NS:0], xs[s-1][XW-1 -: 2]};
        trial = {1'b0, root[s-1], 2'b01};
        bg    = {1'b0, root[s-1]} + (NS+1)'(srem[s-1] > (NS+3)'(root[s-1]));
        dsh   = '0;
        if (s >= S_DIV && s < S_OUT) dsh = den[s-1] << (S_OUT - 1 - s);
        for (int k = 0; k < 3; k++) begin
          mag[k] = dv[k][s-1][W] ? (W+1)'(-dv[k][s-1]) : dv[k][s-1];
          nm[k]  = (RW'(mag[k]) << F) + RW'({big[s-1], 1'b0});
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          xs[s]   <= xs[s-1];
          srem[s] <= srem[s-1];
          root[s] <= root[s-1];
          big[s]  <= big[s-1];
          den[s]  <= den[s-1];
          rt[s]   <= rt[s-1];
          for (int k = 0; k < 3; k++) begin
            dv[k][s]  <= dv[k][s-1];
            num[k][s] <= num[k][s-1];
            qt[k][s]  <= qt[k][s-1];
            ovf[k][s] <= ovf[k][s-1];
          end
          if (s <= NS) begin
            // one root bit per stage, restoring
            xs[s] <= xs[s-1] << 2;
            if (rin >= trial) begin
              srem[s] <= rin - trial;
              root[s] <= {root[s-1][NS-2:0], 1'b1};
            end else begin
              srem[s] <= rin;
              root[s] <= {root[s-1][NS-2:0], 1'b0};
            end
          end else if (s == S_RND) begin
            big[s] <= bg;
          end else if (s == S_NUM) begin
            den[s] <= RW'({big[s-1], 2'b00});
            for (int k = 0; k < 3; k++) begin
              num[k][s] <= nm[k];
              ovf[k][s] <= nm[k] >= (RW'({big[s-1], 2'b00}) << W);
            end
          end else if (s < S_OUT) begin
            // one quotient bit per stage, MSB first
            for (int k = 0; k < 3; k++) begin
              if (num[k][s-1] >= dsh) begin
                num[k][s] <= num[k][s-1] - dsh;
                qt[k][s]  <= {qt[k][s-1][W-2:0], 1'b1};
              end else begin
                qt[k][s]  <= {qt[k][s-1][W-2:0], 1'b0};
              end
            end
          end
        end
      end
    end
  endgenerate

  // output stage: sign, saturate, route
  logic [W-1:0] lane [3];
  logic [W-1:0] bsat;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!dv[k][S_OUT-1][W]) begin
        lane[k] = (ovf[k][S_OUT-1] || qt[k][S_OUT-1] > HI) ? HI : qt[k][S_OUT-1];
      end else begin
        lane[k] = (ovf[k][S_OUT-1] || qt[k][S_OUT-1] > LO) ? LO : W'(-qt[k][S_OUT-1]);
      end
    end
    bsat = (big[S_OUT-1] > (NS+1)'(HI)) ? HI : W'(big[S_OUT-1]);
    unique case (rt[S_OUT-1])
      ROUTE_S: begin
        res[0] = bsat;    res[1] = lane[0]; res[2] = lane[1]; res[3] = lane[2];
      end
      ROUTE_I: begin
        res[0] = lane[0]; res[1] = bsat;    res[2] = lane[1]; res[3] = lane[2];
      end
      ROUTE_J: begin
        res[0] = lane[0]; res[1] = lane[2]; res[2] = bsat;    res[3] = lane[1];
      end
      ROUTE_K: begin
        res[0] = lane[0]; res[1] = lane[1]; res[2] = lane[2]; res[3] = bsat;
      end
      default: begin
        res[0] = '0; res[1] = '0; res[2] = '0; res[3] = '0;
      end
    endcase
  end

  logic [W-1:0] oq [4];
  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      for (int k = 0; k < 4; k++) oq[k] <= res[k];
    end
  end

  assign out_valid = v[S_OUT];
  assign q_scalar  = oq[0];
  assign q_i       = oq[1];
  assign q_j       = oq[2];
  assign q_k       = oq[3];
endmodule

FILE: rtl/rmq_checker.sv
// Port-level checks for rotation_matrix_to_quaternion_unit, bound to it.
// Depends on rmq_pkg and the assertion macro header.
`include "rotation_matrix_to_quaternion_unit_assert.svh"
module rmq_checker import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] q_scalar,
  input logic [DATA_WIDTH-1:0] q_i,
  input logic [DATA_WIDTH-1:0] q_j,
  input logic [DATA_WIDTH-1:0] q_k
);
  // a stalled output word holds
  `RMQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(q_scalar) && $stable(q_i) && $stable(q_j) && $stable(q_k), "output word changed while stalled")

  // an empty output stage means the whole pipe can take a word
  `RMQ_ASSERT_IMP(a_empty_ready, clk, rst, !out_valid, in_ready, "in_ready low with empty output")

  // reset empties the pipe
  `RMQ_ASSERT_RST(a_rst_empty, clk, rst, !out_valid, "output valid right after reset")

  // a waiting input word stays offered until taken
  `RMQ_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid, "input word withdrawn while waiting")
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
  .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_rmq_checker (.*);
